// File: rtl/sge_pkg.sv
// Shared types and constants for the second greater element engine.
// No dependencies; imported by sge_cell, sge_stack and second_greater_element.
`default_nettype none
package sge_pkg;

	localparam int SLOT_W = 6;   // wide enough for a slot of the deepest stack (64)

	typedef struct packed {
		logic              pop;  // shift every cell up by one
		logic              ins;  // insert at slot, cells below shift down
		logic [SLOT_W-1:0] slot;
	} sge_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PLAN,
		ST_RES,
		ST_MOVE,
		ST_PUSH
	} sge_state_t;

endpackage
`default_nettype wire

// File: rtl/sge_cell.sv
// One stack slot: holds an (index, value) pair and compares it to the key.
// Depends on sge_pkg.
`default_nettype none
module sge_cell #(
	parameter int POS   = 0,
	parameter int IDX_W = 16,
	parameter int VAL_W = 31
) (
	input  wire logic              clk,
	input  wire sge_pkg::sge_op_t  op,
	input  wire logic [VAL_W-1:0]  key,
	input  wire logic [IDX_W-1:0]  new_idx,
	input  wire logic [VAL_W-1:0]  new_val,
	input  wire logic [IDX_W-1:0]  up_idx,
	input  wire logic [VAL_W-1:0]  up_val,
	input  wire logic [IDX_W-1:0]  dn_idx,
	input  wire logic [VAL_W-1:0]  dn_val,
	output logic      [IDX_W-1:0]  idx_q,
	output logic      [VAL_W-1:0]  val_q,
	output logic                   gt_q
);
	import sge_pkg::*;

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(POS);

	always_ff @(posedge clk) begin
		gt_q <= key > val_q;
		if (op.pop) begin
			idx_q <= dn_idx;
			val_q <= dn_val;
		end else if (op.ins) begin
			if (op.slot == MY_SLOT) begin
				idx_q <= new_idx;
				val_q <= new_val;
			end else if (op.slot < MY_SLOT) begin
				idx_q <= up_idx;
				val_q <= up_val;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/sge_stack.sv
// Row of sge_cell slots forming a shift stack, top at slot 0.
// Depends on sge_pkg and sge_cell.
`default_nettype none
module sge_stack #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 16,
	parameter int VAL_W = 31
) (
	input  wire logic              clk,
	input  wire sge_pkg::sge_op_t  op,
	input  wire logic [VAL_W-1:0]  key,
	input  wire logic [IDX_W-1:0]  new_idx,
	input  wire logic [VAL_W-1:0]  new_val,
	output logic      [IDX_W-1:0]  top_idx,
	output logic      [VAL_W-1:0]  top_val,
	output logic      [DEPTH-1:0]  gt
);
	import sge_pkg::*;

	logic [IDX_W-1:0] idx_a [DEPTH+1];
	logic [VAL_W-1:0] val_a [DEPTH+1];

	// bottom neighbor of the deepest slot feeds zeros
	assign idx_a[DEPTH] = '0;
	assign val_a[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sge_cell #(.POS(i), .IDX_W(IDX_W), .VAL_W(VAL_W)) u_cell (
			.clk     (clk),
			.op      (op),
			.key     (key),
			.new_idx (new_idx),
			.new_val (new_val),
			.up_idx  ((i == 0) ? new_idx : idx_a[(i == 0) ? 0 : i-1]),
			.up_val  ((i == 0) ? new_val : val_a[(i == 0) ? 0 : i-1]),
			.dn_idx  (idx_a[i+1]),
			.dn_val  (val_a[i+1]),
			.idx_q   (idx_a[i]),
			.val_q   (val_a[i]),
			.gt_q    (gt[i])
		);
	end

	assign top_idx = idx_a[0];
	assign top_val = val_a[0];

endmodule
`default_nettype wire

// File: rtl/second_greater_element.sv
// Top level of the second greater element engine (two monotonic stacks of cells).
// Depends on sge_pkg and sge_stack.
//
//  Channel | Dir | Signals            | Contents
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | tvalid/tready      | tdata: value[30:0], pad; tuser: start_req
//  m_      | out | tvalid/tready      | tdata: index[15:0], answer_value[46:16],
//          |     |                    | pad; tlast: last; tuser: overflow
//
// A beat is accepted in idle, then passes compare, plan, a resolve phase that pops each
// resolved entry (r), a move phase that moves or drops each first-stack entry below the
// key (k), and a push; output stalls lengthen the resolve phase. The stacks are rows of
// cells that shift one slot per cycle while no output stall holds the resolve phase.
// arst_n clears counters, position, overflow and the output valid; stack contents
// stay undefined and are never read past the counts. A stalled m_ side holds the
// resolve phase; s_tready is high only between beats.
`default_nettype none
module second_greater_element #(
	parameter int STACK_DEPTH = 64,
	parameter int INDEX_BITS  = 16,
	parameter int VALUE_BITS  = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [30:0] value, [31] zero
	input  wire logic        s_tuser,   // [0] start_req
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // [15:0] index, [46:16] answer_value, [47] zero
	output logic             m_tlast,   // last result of this beat
	output logic             m_tuser    // [0] overflow
);
	import sge_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	sge_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] key_q;
	logic [INDEX_BITS-1:0] pos_q;
	logic [CNT_W-1:0]      c1_q, c2_q, r_q, drop_q, mv_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  ovf_q;

	logic                  out_vld_q, out_last_q, out_ovf_q;
	logic [15:0]           out_idx_q;
	logic [30:0]           out_ans_q;

	sge_op_t               op1, op2;
	logic [INDEX_BITS-1:0] s1_top_idx, s2_top_idx;
	logic [VALUE_BITS-1:0] s1_top_val, s2_top_val;
	logic [STACK_DEPTH-1:0] gt1, gt2, live1, live2;

	logic [CNT_W-1:0]      r_c, k_c, space_c, m_c;
	logic [INDEX_BITS-1:0] pos_inc;
	logic                  out_free, accept;

	sge_stack #(.DEPTH(STACK_DEPTH), .IDX_W(INDEX_BITS), .VAL_W(VALUE_BITS)) u_first (
		.clk(clk), .op(op1), .key(key_q), .new_idx(pos_q), .new_val(key_q),
		.top_idx(s1_top_idx), .top_val(s1_top_val), .gt(gt1)
	);

	sge_stack #(.DEPTH(STACK_DEPTH), .IDX_W(INDEX_BITS), .VAL_W(VALUE_BITS)) u_second (
		.clk(clk), .op(op2), .key(key_q), .new_idx(s1_top_idx), .new_val(s1_top_val),
		.top_idx(s2_top_idx), .top_val(s2_top_val), .gt(gt2)
	);

	// only slots below the fill count take part in the plan
	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			live1[i] = CNT_W'(i) < c1_q;
			live2[i] = CNT_W'(i) < c2_q;
		end
	end

	// both stacks stay sorted (smallest on top), so exceeded slots form a run from the top
	assign r_c     = CNT_W'($countones(gt2 & live2));
	assign k_c     = CNT_W'($countones(gt1 & live1));
	assign space_c = DEPTH_C - (c2_q - r_c);
	assign m_c     = (k_c < space_c) ? k_c : space_c;
	assign pos_inc = pos_q + 1'b1;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op1     = '0;
		op2     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CMP;
			end
			ST_CMP:  state_d = ST_PLAN;
			ST_PLAN: state_d = ST_RES;
			ST_RES: begin
				if (r_q == '0) begin
					state_d = ST_MOVE;
				end else if (out_free) begin
					op2.pop = 1'b1;
				end
			end
			ST_MOVE: begin
				if (drop_q != '0) begin
					op1.pop = 1'b1;
				end else if (mv_q != '0) begin
					op1.pop  = 1'b1;
					op2.ins  = 1'b1;
					op2.slot = slot_q;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				op1.ins = (c1_q < DEPTH_C);
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// counters and flags of the item at work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q   <= '0;
			c2_q   <= '0;
			pos_q  <= '0;
			ovf_q  <= 1'b0;
			r_q    <= '0;
			drop_q <= '0;
			mv_q   <= '0;
			slot_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser) begin
						c1_q  <= '0;
						c2_q  <= '0;
						pos_q <= '0;
					end
				end
				ST_PLAN: begin
					r_q    <= r_c;
					mv_q   <= m_c;
					drop_q <= k_c - m_c;
					slot_q <= '0;
					// fix the sticky flag now so every result of this beat carries it
					if ((k_c > space_c) || ((c1_q - k_c) == DEPTH_C) || (pos_inc == '0))
						ovf_q <= 1'b1;
				end
				ST_RES: begin
					if (r_q != '0 && out_free) begin
						r_q  <= r_q - 1'b1;
						c2_q <= c2_q - 1'b1;
					end
				end
				ST_MOVE: begin
					if (drop_q != '0) begin
						drop_q <= drop_q - 1'b1;
						c1_q   <= c1_q - 1'b1;
					end else if (mv_q != '0) begin
						mv_q   <= mv_q - 1'b1;
						c1_q   <= c1_q - 1'b1;
						c2_q   <= c2_q + 1'b1;
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_PUSH: begin
					if (c1_q < DEPTH_C) c1_q <= c1_q + 1'b1;
					pos_q <= pos_inc;
				end
				default: ;
			endcase
		end
	end

	// hold the key for the whole beat
	always_ff @(posedge clk) begin
		if (accept) key_q <= VALUE_BITS'(s_tdata[30:0]);
	end

	// output register: load one result per resolved entry, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_RES && r_q != '0 && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RES && r_q != '0 && out_free) begin
			out_idx_q  <= 16'(s2_top_idx);
			out_ans_q  <= 31'(key_q);
			out_last_q <= (r_q == CNT_W'(1));
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_ans_q, out_idx_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for second_greater_element: table, random arrays, drop-off run.
// Depends on sge_pkg and the second_greater_element RTL; nothing else.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import sge_pkg::*;

	localparam int DEPTH = 64;

	// expected output beat
	typedef struct packed {
		logic [15:0] index;
		logic [30:0] answer_value;
		logic        last;
		logic        overflow;
	} sge_result_t;

	typedef struct packed {
		logic [30:0] value;
		logic        start_req;
		logic        check_row;   // typed-in expectation present
		logic [15:0] row_index;
		logic        row_ovf;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	second_greater_element dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// predictor state: two stacks of (position, value)
	logic [15:0] first_idx [DEPTH];
	logic [30:0] first_val [DEPTH];
	logic [15:0] second_idx [DEPTH];
	logic [30:0] second_val [DEPTH];
	int          first_depth = 0;
	int          second_depth = 0;
	logic [15:0] next_pos = '0;
	logic        sticky_ovf = 1'b0;

	sge_result_t pending_answers [$];
	bit          head_found = 1'b0;   // last element produced at least one answer
	sge_result_t head_ans;            // first answer of the last element
	int          mismatches = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          ovf_seen = 0;
	bit          hold_off = 1'b0;   // receiver long stall request
	bit          sender_done = 1'b0;

	// Advance predictor by one element, queue the resolved answers.
	task automatic predict_element(input logic [30:0] v, input logic start);
		sge_result_t r;
		int          base, k, i, first_new;
		first_new = pending_answers.size();
		if (start) begin
			first_depth = 0;
			second_depth = 0;
			next_pos = '0;
		end
		while (second_depth > 0 && v > second_val[second_depth-1]) begin
			second_depth--;
			r.index = second_idx[second_depth];
			r.answer_value = v;
			r.last = 1'b0;
			r.overflow = 1'b0;
			pending_answers.push_back(r);
		end
		k = 0;
		while (k < first_depth && v > first_val[first_depth-1-k])
			k++;
		base = first_depth - k;
		for (i = base; i < first_depth; i++) begin
			if (second_depth < DEPTH) begin
				second_idx[second_depth] = first_idx[i];
				second_val[second_depth] = first_val[i];
				second_depth++;
			end else begin
				sticky_ovf = 1'b1;
			end
		end
		first_depth = base;
		if (first_depth < DEPTH) begin
			first_idx[first_depth] = next_pos;
			first_val[first_depth] = v;
			first_depth++;
		end else begin
			sticky_ovf = 1'b1;
		end
		next_pos = next_pos + 16'd1;
		if (next_pos == 16'd0)
			sticky_ovf = 1'b1;
		for (i = first_new; i < pending_answers.size(); i++)
			pending_answers[i].overflow = sticky_ovf;
		if (pending_answers.size() > first_new)
			pending_answers[pending_answers.size()-1].last = 1'b1;
		head_found = (pending_answers.size() > first_new);
		if (head_found)
			head_ans = pending_answers[first_new];
	endtask

	// Mostly short gaps, a few long ones, and runs with none.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one beat on the falling edge and hold until accepted.
	// Valid stays up on return; the next call drops it before a gap.
	task automatic send_element(input logic [30:0] v, input logic start);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tdata <= {1'b0, v};
		s_tuser <= start;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_element(v, start);
		beats_in++;
		@(negedge clk);
	endtask

	// Directed table: extremes, equal values, start mid-array.
	// Rows with check_row set carry the first answer of that element by hand.
	localparam int N_ROWS = 20;
	stim_row_t table_rows [N_ROWS] = '{
		'{31'd5,          1'b1, 1'b0, 16'd0, 1'b0},
		'{31'd0,          1'b0, 1'b0, 16'd0, 1'b0},
		'{31'd7,          1'b0, 1'b0, 16'd0, 1'b0},   // moves 0 and 5
		'{31'd9,          1'b0, 1'b1, 16'd1, 1'b0},   // resolves index 1 first
		'{31'd9,          1'b0, 1'b0, 16'd0, 1'b0},   // equal to the 9 below: not moved
		'{31'h7FFF_FFFF,  1'b0, 1'b0, 16'd0, 1'b0},
		'{31'h7FFF_FFFF,  1'b0, 1'b0, 16'd0, 1'b0},
		'{31'd0,          1'b1, 1'b0, 16'd0, 1'b0},   // new array
		'{31'd1,          1'b0, 1'b0, 16'd0, 1'b0},
		'{31'd2,          1'b0, 1'b1, 16'd0, 1'b0},   // index 0 gets 2
		'{31'h5555_5555,  1'b0, 1'b0, 16'd0, 1'b0},
		'{31'h2AAA_AAAA,  1'b0, 1'b0, 16'd0, 1'b0},
		'{31'h7FFF_FFFF,  1'b0, 1'b0, 16'd0, 1'b0},
		'{31'd3,          1'b1, 1'b0, 16'd0, 1'b0},
		'{31'd3,          1'b0, 1'b0, 16'd0, 1'b0},
		'{31'd3,          1'b0, 1'b0, 16'd0, 1'b0},
		'{31'd4,          1'b0, 1'b0, 16'd0, 1'b0},
		'{31'd5,          1'b0, 1'b1, 16'd2, 1'b0},   // top of second stack is index 2
		'{31'd1,          1'b1, 1'b0, 16'd0, 1'b0},
		'{31'd0,          1'b0, 1'b0, 16'd0, 1'b0}
	};

	// Sender: table, random arrays, then the stack-overflow run.
	initial begin : sender
		int          row, n, i, len, kind;
		logic [30:0] v;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (row = 0; row < N_ROWS; row++) begin
			send_element(table_rows[row].value, table_rows[row].start_req);
			// hand-typed expectation must agree with the predictor's head answer
			if (table_rows[row].check_row && (!head_found ||
				head_ans.index != table_rows[row].row_index ||
				head_ans.overflow != table_rows[row].row_ovf)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: expected index %0d not predicted", row,
						table_rows[row].row_index);
			end
		end
		// random arrays of well-formed shape with random content
		n = 0;
		while (n < 370) begin
			len = $urandom_range(1, 24);
			kind = $urandom_range(0, 3);
			for (i = 0; i < len; i++) begin
				case (kind)
					0: v = 31'($urandom_range(0, 15));
					1: v = 31'(i * 3 + $urandom_range(0, 5));
					2: v = 31'(200 - i * 5 + $urandom_range(0, 20));
					default: v = 31'($urandom);
				endcase
				send_element(v, i == 0);
				n++;
			end
			if (n > 150 && n < 175) hold_off = 1'b1;
		end
		// descending run fills the first stack: drops, then sticky overflow
		for (i = 0; i < 70; i++)
			send_element(31'(1000 - i), i == 0);
		send_element(31'h7FFF_FFFF, 1'b0);   // moves a full stack at once
		send_element(31'h7FFF_FFFF, 1'b0);
		send_element(31'd2, 1'b0);
		s_tvalid <= 1'b0;
		sender_done = 1'b1;
	end

	// Receiver: random stalls, plus one long hold-off so the input backs up.
	initial begin : receiver
		int g;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Scoreboard: compare each accepted beat with the oldest answer.
	always @(posedge clk) begin
		sge_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_out++;
			if (m_tuser) ovf_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: index %0d value %0d", m_tdata[15:0],
						m_tdata[46:16]);
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[15:0] != want.index || m_tdata[46:16] != want.answer_value ||
					m_tdata[47] != 1'b0 || m_tlast != want.last ||
					m_tuser != want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp idx %0d val %0d last %b ovf %b, got %0d %0d %b %b",
							want.index, want.answer_value, want.last, want.overflow,
							m_tdata[15:0], m_tdata[46:16], m_tlast, m_tuser);
				end
			end
		end
	end

	initial begin : finisher
		wait (sender_done);
		wait (pending_answers.size() == 0);
		repeat (300) @(posedge clk);
		$display("covered %0d input beats and %0d result beats, %0d with overflow set",
			beats_in, beats_out, ovf_seen);
		$display("directed extremes, equal values, random arrays and stack drop-off done");
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#100ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
